[design/apstep_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apstep_pkg
// Shared widths, constants, register indexes and the arctangent table of the
// antenna pointing pipeline.
// ----------------------------------------------------------------------------
package apstep_pkg;

   // field widths
   localparam int POS_W      = 32;
   localparam int ANG_W      = 16;
   localparam int TP_W       = 15;
   localparam int STEP_W     = 18;
   localparam int SPD_W      = 27;
   localparam int GAIN_W     = 16;
   localparam int PER_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OFFSET_NORTH = 3'd0,
      REG_OFFSET_EAST  = 3'd1,
      REG_YAW_GAIN     = 3'd2,
      REG_PITCH_GAIN   = 3'd3,
      REG_PERIOD_MS    = 3'd4
   } csr_reg_type;

   localparam int unsigned YAW_GAIN_MAX_DEF   = 32768;
   localparam int unsigned PITCH_GAIN_MAX_DEF = 32768;
   localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd16384;
   localparam logic [PER_W-1:0]  PERIOD_RESET = 16'd100;

   // normalisation and square root
   localparam int MAG_W       = 33;
   localparam int NORM_W      = 30;
   localparam int SQ_IN_W     = 61;
   localparam int SQ_R_W      = 62;
   localparam int HYP_W       = 31;
   localparam int SQRT_STEPS  = 31;

   // cordic
   localparam int CORDIC_STEPS = 20;
   localparam int CRD_W        = 34;
   localparam int Z_W          = 25;
   localparam int TAB_W        = 23;
   localparam int ANG90_Z      = 5898240;

   // angles, 1/128 degree
   localparam int DEG180 = 23040;
   localparam int DEG360 = 46080;

   // speed
   localparam int DIV_W       = 32;
   localparam int DEN_W       = 20;
   localparam int SPEED_SCALE = 12800;
   localparam int SPEED_MAX   = 131072000;

   // atan(2^-i) in 2^-16 degree
   function automatic logic [TAB_W-1:0] atan_entry(input int unsigned i);
      logic [TAB_W-1:0] v;
      case (i)
         0:  v = 23'd2949120;
         1:  v = 23'd1740967;
         2:  v = 23'd919879;
         3:  v = 23'd475137;
         4:  v = 23'd234379;
         5:  v = 23'd117304;
         6:  v = 23'd58666;
         7:  v = 23'd29335;
         8:  v = 23'd14668;
         9:  v = 23'd7334;
         10: v = 23'd3667;
         11: v = 23'd1833;
         12: v = 23'd917;
         13: v = 23'd458;
         14: v = 23'd229;
         15: v = 23'd115;
         16: v = 23'd57;
         17: v = 23'd29;
         18: v = 23'd14;
         19: v = 23'd7;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[design/apstep_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apstep channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface apstep_req_if;
   import apstep_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] target_north;
   logic signed [POS_W-1:0] target_east;
   logic signed [POS_W-1:0] target_down;
   logic signed [ANG_W-1:0] measured_yaw;
   logic signed [ANG_W-1:0] measured_pitch;
   modport source (output valid, target_north, target_east, target_down,
                   measured_yaw, measured_pitch, input ready);
   modport sink (input valid, target_north, target_east, target_down,
                 measured_yaw, measured_pitch, output ready);
endinterface

interface apstep_rsp_if;
   import apstep_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [STEP_W-1:0] yaw_step;
   logic signed [STEP_W-1:0] pitch_step;
   logic [SPD_W-1:0]         horizontal_speed;
   logic [SPD_W-1:0]         vertical_speed;
   logic signed [ANG_W-1:0]  target_yaw;
   logic signed [TP_W-1:0]   target_pitch;
   modport source (output valid, yaw_step, pitch_step, horizontal_speed,
                   vertical_speed, target_yaw, target_pitch, input ready);
   modport sink (input valid, yaw_step, pitch_step, horizontal_speed,
                 vertical_speed, target_yaw, target_pitch, output ready);
endinterface

interface apstep_csr_if;
   import apstep_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[design/apstep_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apstep_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module apstep_sqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [apstep_pkg::SQ_IN_W-1:0] in_value,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic [apstep_pkg::HYP_W-1:0] out_root,
   output logic [SIDE_W-1:0]            out_side
);
   import apstep_pkg::*;

   logic [SQRT_STEPS:0] v_ff;
   logic [SQ_R_W-1:0]   rem_ff  [0:SQRT_STEPS];
   logic [SQ_R_W-1:0]   root_ff [0:SQRT_STEPS];
   logic [SIDE_W-1:0]   side_ff [0:SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[SQRT_STEPS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= SQ_R_W'(in_value);
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
      localparam logic [SQ_R_W-1:0] BIT = SQ_R_W'(1) << (2 * (SQRT_STEPS - 1 - s));
      logic [SQ_R_W-1:0] trial;
      assign trial = root_ff[s] + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[s] >= trial) begin
               rem_ff[s+1]  <= rem_ff[s] - trial;
               root_ff[s+1] <= (root_ff[s] >> 1) + BIT;
            end else begin
               rem_ff[s+1]  <= rem_ff[s];
               root_ff[s+1] <= root_ff[s] >> 1;
            end
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = v_ff[SQRT_STEPS];
   assign out_root  = root_ff[SQRT_STEPS][HYP_W-1:0];
   assign out_side  = side_ff[SQRT_STEPS];

endmodule

[design/apstep_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apstep_cordic
// Pipelined vectoring cordic, first quadrant atan2 in 2^-16 degree, clamped
// to 0..90 degree, with sideband.
// ----------------------------------------------------------------------------
module apstep_cordic #(
   parameter int SIDE_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [apstep_pkg::HYP_W-1:0] in_x,
   input  logic [apstep_pkg::HYP_W-1:0] in_y,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic [apstep_pkg::TAB_W-1:0] out_angle,
   output logic [SIDE_W-1:0]            out_side
);
   import apstep_pkg::*;

   logic [CORDIC_STEPS:0]    v_ff;
   logic signed [CRD_W-1:0]  x_ff    [0:CORDIC_STEPS];
   logic signed [CRD_W-1:0]  y_ff    [0:CORDIC_STEPS];
   logic signed [Z_W-1:0]    z_ff    [0:CORDIC_STEPS];
   logic [CORDIC_STEPS:0]    ay0_ff;
   logic [CORDIC_STEPS:0]    ax0_ff;
   logic [SIDE_W-1:0]        side_ff [0:CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[CORDIC_STEPS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= signed'(CRD_W'(in_x));
         y_ff[0]    <= signed'(CRD_W'(in_y));
         z_ff[0]    <= '0;
         ay0_ff[0]  <= (in_y == '0);
         ax0_ff[0]  <= (in_x == '0);
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_iter
      logic signed [CRD_W-1:0] dx;
      logic signed [CRD_W-1:0] dy;
      logic signed [Z_W-1:0]   ta;
      assign dx = y_ff[s] >>> s;
      assign dy = x_ff[s] >>> s;
      assign ta = signed'(Z_W'(atan_entry(s)));
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[s] > 0) begin
               x_ff[s+1] <= x_ff[s] + dx;
               y_ff[s+1] <= y_ff[s] - dy;
               z_ff[s+1] <= z_ff[s] + ta;
            end else begin
               x_ff[s+1] <= x_ff[s] - dx;
               y_ff[s+1] <= y_ff[s] + dy;
               z_ff[s+1] <= z_ff[s] - ta;
            end
            ay0_ff[s+1]  <= ay0_ff[s];
            ax0_ff[s+1]  <= ax0_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   logic signed [Z_W-1:0] z_last;
   assign z_last = z_ff[CORDIC_STEPS];

   always_comb begin
      if (ay0_ff[CORDIC_STEPS]) begin
         out_angle = '0;
      end else if (ax0_ff[CORDIC_STEPS]) begin
         out_angle = TAB_W'(ANG90_Z);
      end else if (z_last < 0) begin
         out_angle = '0;
      end else if (z_last > Z_W'(ANG90_Z)) begin
         out_angle = TAB_W'(ANG90_Z);
      end else begin
         out_angle = TAB_W'(z_last);
      end
   end

   assign out_valid = v_ff[CORDIC_STEPS];
   assign out_side  = side_ff[CORDIC_STEPS];

endmodule

[design/apstep_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apstep_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module apstep_div #(
   parameter int SIDE_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [apstep_pkg::DIV_W-1:0] in_num,
   input  logic [apstep_pkg::DEN_W-1:0] den,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic [apstep_pkg::DIV_W-1:0] out_quot,
   output logic [SIDE_W-1:0]            out_side
);
   import apstep_pkg::*;

   logic [DIV_W:0]      v_ff;
   logic [DIV_W-1:0]    nq_ff   [0:DIV_W];
   logic [DEN_W-1:0]    rem_ff  [0:DIV_W];
   logic [SIDE_W-1:0]   side_ff [0:DIV_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[DIV_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nq_ff[0]   <= in_num;
         rem_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 0; s < DIV_W; s++) begin : g_step
      logic [DEN_W:0] trial;
      assign trial = {rem_ff[s], nq_ff[s][DIV_W-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            if (trial >= {1'b0, den}) begin
               rem_ff[s+1] <= DEN_W'(trial - {1'b0, den});
               nq_ff[s+1]  <= {nq_ff[s][DIV_W-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= trial[DEN_W-1:0];
               nq_ff[s+1]  <= {nq_ff[s][DIV_W-2:0], 1'b0};
            end
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = v_ff[DIV_W];
   assign out_quot  = nq_ff[DIV_W];
   assign out_side  = side_ff[DIV_W];

endmodule

[design/antenna_pointing_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// antenna_pointing_step
// Throughput: one word per cycle unless the response is stalled; the 31-stage
// square root, two 20-stage cordics and two 32-stage dividers each take a new
// word every cycle that the pipeline advances.
// The whole pipeline advances together and holds while the response is stalled.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module antenna_pointing_step #(
   parameter int unsigned YAW_GAIN_MAX   = apstep_pkg::YAW_GAIN_MAX_DEF,
   parameter int unsigned PITCH_GAIN_MAX = apstep_pkg::PITCH_GAIN_MAX_DEF
) (
   input  logic         clock,
   input  logic         reset,
   apstep_req_if.sink   req_ch,
   apstep_rsp_if.source rsp_ch,
   apstep_csr_if.sink   csr_ch
);
   import apstep_pkg::*;

   localparam int TOP_BIT = NORM_W - 1;
   localparam int SQ_SIDE_W = 3 * NORM_W + 3 + 2 * ANG_W;
   localparam int YC_SIDE_W = 2 + 2 * ANG_W;
   localparam int YD_SIDE_W = STEP_W + ANG_W;
   localparam int PD_SIDE_W = STEP_W + TP_W;

   // registers
   logic signed [POS_W-1:0] off_n_ff, off_e_ff;
   logic [GAIN_W-1:0]       yaw_gain_ff, pitch_gain_ff;
   logic [PER_W-1:0]        period_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_n_ff      <= '0;
         off_e_ff      <= '0;
         yaw_gain_ff   <= GAIN_RESET;
         pitch_gain_ff <= GAIN_RESET;
         period_ff     <= PERIOD_RESET;
      end else if (csr_ch.valid) begin
         case (csr_reg_type'(csr_ch.index))
            REG_OFFSET_NORTH: off_n_ff      <= signed'(csr_ch.data);
            REG_OFFSET_EAST:  off_e_ff      <= signed'(csr_ch.data);
            REG_YAW_GAIN:     yaw_gain_ff   <= csr_ch.data[GAIN_W-1:0];
            REG_PITCH_GAIN:   pitch_gain_ff <= csr_ch.data[GAIN_W-1:0];
            REG_PERIOD_MS:    period_ff     <= csr_ch.data[PER_W-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // stage 1: offsets
   logic                    v1_ff;
   logic signed [MAG_W-1:0] n1_ff, e1_ff;
   logic signed [POS_W-1:0] d1_ff;
   logic signed [ANG_W-1:0] my1_ff, mp1_ff;

   // stage 2: magnitudes and largest
   logic                 v2_ff;
   logic [MAG_W-1:0]     un2_ff, ue2_ff, ud2_ff, m2_ff;
   logic                 xneg2_ff, yneg2_ff, pneg2_ff;
   logic signed [ANG_W-1:0] my2_ff, mp2_ff;
   logic [MAG_W-1:0]     un2_in, ue2_in, ud2_in, m2_in;

   // stage 3: normalised
   logic                 v3_ff;
   logic [NORM_W-1:0]    un3_ff, ue3_ff, ud3_ff;
   logic                 xneg3_ff, yneg3_ff, pneg3_ff;
   logic signed [ANG_W-1:0] my3_ff, mp3_ff;
   logic [NORM_W-1:0]    un3_in, ue3_in, ud3_in;
   logic [5:0]           pos, sh;

   // stage 4: squares
   logic                 v4_ff;
   logic [2*NORM_W-1:0]  nn4_ff, ee4_ff;
   logic [SQ_SIDE_W-1:0] side4_ff;

   // stage 5: sum
   logic                 v5_ff;
   logic [SQ_IN_W-1:0]   sum5_ff;
   logic [SQ_SIDE_W-1:0] side5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_ch.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_comb begin
      un2_in = n1_ff < 0 ? MAG_W'(-n1_ff) : MAG_W'(n1_ff);
      ue2_in = e1_ff < 0 ? MAG_W'(-e1_ff) : MAG_W'(e1_ff);
      ud2_in = d1_ff < 0 ? MAG_W'(unsigned'(-d1_ff)) : MAG_W'(unsigned'(d1_ff));
      m2_in  = un2_in > ue2_in ? un2_in : ue2_in;
      if (ud2_in > m2_in) begin
         m2_in = ud2_in;
      end
   end

   always_comb begin
      pos = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (m2_ff[i]) begin
            pos = 6'(i);
         end
      end
      if (pos > 6'(TOP_BIT)) begin
         sh     = pos - 6'(TOP_BIT);
         un3_in = NORM_W'(un2_ff >> sh);
         ue3_in = NORM_W'(ue2_ff >> sh);
         ud3_in = NORM_W'(ud2_ff >> sh);
      end else begin
         sh     = 6'(TOP_BIT) - pos;
         un3_in = NORM_W'(un2_ff << sh);
         ue3_in = NORM_W'(ue2_ff << sh);
         ud3_in = NORM_W'(ud2_ff << sh);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_ff  <= $signed({req_ch.target_north[POS_W-1], req_ch.target_north})
                 + $signed({off_n_ff[POS_W-1], off_n_ff});
         e1_ff  <= $signed({req_ch.target_east[POS_W-1], req_ch.target_east})
                 + $signed({off_e_ff[POS_W-1], off_e_ff});
         d1_ff  <= req_ch.target_down;
         my1_ff <= req_ch.measured_yaw;
         mp1_ff <= req_ch.measured_pitch;

         un2_ff   <= un2_in;
         ue2_ff   <= ue2_in;
         ud2_ff   <= ud2_in;
         m2_ff    <= m2_in;
         xneg2_ff <= n1_ff < 0;
         yneg2_ff <= e1_ff < 0;
         pneg2_ff <= d1_ff > 0;
         my2_ff   <= my1_ff;
         mp2_ff   <= mp1_ff;

         un3_ff   <= un3_in;
         ue3_ff   <= ue3_in;
         ud3_ff   <= ud3_in;
         xneg3_ff <= xneg2_ff;
         yneg3_ff <= yneg2_ff;
         pneg3_ff <= pneg2_ff;
         my3_ff   <= my2_ff;
         mp3_ff   <= mp2_ff;

         nn4_ff   <= un3_ff * un3_ff;
         ee4_ff   <= ue3_ff * ue3_ff;
         side4_ff <= {un3_ff, ue3_ff, ud3_ff, xneg3_ff, yneg3_ff, pneg3_ff,
                      my3_ff, mp3_ff};

         sum5_ff  <= SQ_IN_W'(nn4_ff) + SQ_IN_W'(ee4_ff);
         side5_ff <= side4_ff;
      end
   end

   // horizontal distance
   logic                 sq_valid;
   logic [HYP_W-1:0]     hyp;
   logic [SQ_SIDE_W-1:0] sq_side;

   apstep_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v5_ff),
      .in_value  (sum5_ff),
      .in_side   (side5_ff),
      .out_valid (sq_valid),
      .out_root  (hyp),
      .out_side  (sq_side)
   );

   logic [NORM_W-1:0]       s_un, s_ue, s_ud;
   logic                    s_xneg, s_yneg, s_pneg;
   logic signed [ANG_W-1:0] s_my, s_mp;
   assign {s_un, s_ue, s_ud, s_xneg, s_yneg, s_pneg, s_my, s_mp} = sq_side;

   // angles
   logic                 yc_valid, pc_valid;
   logic [TAB_W-1:0]     yc_angle, pc_angle;
   logic [YC_SIDE_W-1:0] yc_side;
   logic                 pc_side;

   apstep_cordic #(.SIDE_W(YC_SIDE_W)) u_cordic_yaw (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .in_x      (HYP_W'(s_un)),
      .in_y      (HYP_W'(s_ue)),
      .in_side   ({s_xneg, s_yneg, s_my, s_mp}),
      .out_valid (yc_valid),
      .out_angle (yc_angle),
      .out_side  (yc_side)
   );

   apstep_cordic #(.SIDE_W(1)) u_cordic_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .in_x      (hyp),
      .in_y      (HYP_W'(s_ud)),
      .in_side   (s_pneg),
      .out_valid (pc_valid),
      .out_angle (pc_angle),
      .out_side  (pc_side)
   );

   logic                    c_xneg, c_yneg;
   logic signed [ANG_W-1:0] c_my, c_mp;
   assign {c_xneg, c_yneg, c_my, c_mp} = yc_side;

   // stage f: quadrant, rounding to 1/128 degree
   logic                    vf_ff;
   logic signed [ANG_W-1:0] tyaw_f_ff, my_f_ff, mp_f_ff;
   logic signed [TP_W-1:0]  tpitch_f_ff;
   logic [TP_W-1:0]         ry, rp;
   logic signed [ANG_W-1:0] ty_in;
   logic signed [TP_W-1:0]  tp_in;

   always_comb begin
      ry = TP_W'((24'(yc_angle) + 24'd256) >> 9);
      rp = TP_W'((24'(pc_angle) + 24'd256) >> 9);
      ty_in = c_xneg ? signed'(16'(DEG180) - 16'(ry)) : signed'(16'(ry));
      if (c_yneg) begin
         ty_in = -ty_in;
      end
      tp_in = pc_side ? -signed'(rp) : signed'(rp);
   end

   // stage g: wrap, stage h: gain, stage i: speed numerator
   logic                    vg_ff, vh_ff, vi_ff;
   logic signed [ANG_W-1:0] tyaw_g_ff, tyaw_h_ff, tyaw_i_ff;
   logic signed [TP_W-1:0]  tpitch_g_ff, tpitch_h_ff, tpitch_i_ff;
   logic [TP_W-1:0]         ymag_g_ff, pmag_g_ff;
   logic                    yneg_g_ff, pneg_g_ff;
   logic signed [ANG_W:0]   yd, pd, yw, pw;
   logic [STEP_W-2:0]       ymag_h_ff, pmag_h_ff;
   logic signed [STEP_W-1:0] ystep_h_ff, pstep_h_ff, ystep_i_ff, pstep_i_ff;
   logic [DIV_W-1:0]        ynum_i_ff, pnum_i_ff;
   logic [GAIN_W-1:0]       ygain, pgain;
   logic [DIV_W-1:0]        yprod, pprod;
   logic [STEP_W-2:0]       ymag_in, pmag_in;
   logic [PER_W-1:0]        per_eff;
   logic [DEN_W-1:0]        den;

   always_comb begin
      yd = $signed({tyaw_f_ff[ANG_W-1], tyaw_f_ff}) - $signed({my_f_ff[ANG_W-1], my_f_ff});
      pd = $signed({{2{tpitch_f_ff[TP_W-1]}}, tpitch_f_ff})
         - $signed({mp_f_ff[ANG_W-1], mp_f_ff});
      if (yd > 17'sd23040) begin
         yw = yd - 17'sd46080;
      end else if (yd < -17'sd23040) begin
         yw = yd + 17'sd46080;
      end else begin
         yw = yd;
      end
      if (pd > 17'sd23040) begin
         pw = pd - 17'sd46080;
      end else if (pd < -17'sd23040) begin
         pw = pd + 17'sd46080;
      end else begin
         pw = pd;
      end
   end

   always_comb begin
      ygain   = (yaw_gain_ff > GAIN_W'(YAW_GAIN_MAX)) ? GAIN_W'(YAW_GAIN_MAX) : yaw_gain_ff;
      pgain   = (pitch_gain_ff > GAIN_W'(PITCH_GAIN_MAX)) ?
                GAIN_W'(PITCH_GAIN_MAX) : pitch_gain_ff;
      yprod   = DIV_W'(ymag_g_ff) * DIV_W'(ygain);
      pprod   = DIV_W'(pmag_g_ff) * DIV_W'(pgain);
      ymag_in = (STEP_W-1)'((yprod + 32'd8192) >> 14);
      pmag_in = (STEP_W-1)'((pprod + 32'd8192) >> 14);
      per_eff = (period_ff == '0) ? PER_W'(1) : period_ff;
      den     = (DEN_W'(per_eff) << 3) + DEN_W'(per_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
         vh_ff <= 1'b0;
         vi_ff <= 1'b0;
      end else if (adv) begin
         vf_ff <= yc_valid && pc_valid;
         vg_ff <= vf_ff;
         vh_ff <= vg_ff;
         vi_ff <= vh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tyaw_f_ff   <= ty_in;
         tpitch_f_ff <= tp_in;
         my_f_ff     <= c_my;
         mp_f_ff     <= c_mp;

         tyaw_g_ff   <= tyaw_f_ff;
         tpitch_g_ff <= tpitch_f_ff;
         yneg_g_ff   <= yw < 0;
         pneg_g_ff   <= pw < 0;
         ymag_g_ff   <= TP_W'(yw < 0 ? -yw : yw);
         pmag_g_ff   <= TP_W'(pw < 0 ? -pw : pw);

         tyaw_h_ff   <= tyaw_g_ff;
         tpitch_h_ff <= tpitch_g_ff;
         ymag_h_ff   <= ymag_in;
         pmag_h_ff   <= pmag_in;
         ystep_h_ff  <= yneg_g_ff ? -signed'(STEP_W'(ymag_in)) : signed'(STEP_W'(ymag_in));
         pstep_h_ff  <= pneg_g_ff ? -signed'(STEP_W'(pmag_in)) : signed'(STEP_W'(pmag_in));

         tyaw_i_ff   <= tyaw_h_ff;
         tpitch_i_ff <= tpitch_h_ff;
         ystep_i_ff  <= ystep_h_ff;
         pstep_i_ff  <= pstep_h_ff;
         ynum_i_ff   <= DIV_W'(ymag_h_ff) * DIV_W'(SPEED_SCALE) + DIV_W'(den >> 1);
         pnum_i_ff   <= DIV_W'(pmag_h_ff) * DIV_W'(SPEED_SCALE) + DIV_W'(den >> 1);
      end
   end

   // speeds
   logic                 yd_valid, pd_valid;
   logic [DIV_W-1:0]     yquot, pquot;
   logic [YD_SIDE_W-1:0] yd_side;
   logic [PD_SIDE_W-1:0] pd_side;

   apstep_div #(.SIDE_W(YD_SIDE_W)) u_div_yaw (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (vi_ff),
      .in_num    (ynum_i_ff),
      .den       (den),
      .in_side   ({ystep_i_ff, tyaw_i_ff}),
      .out_valid (yd_valid),
      .out_quot  (yquot),
      .out_side  (yd_side)
   );

   apstep_div #(.SIDE_W(PD_SIDE_W)) u_div_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (vi_ff),
      .in_num    (pnum_i_ff),
      .den       (den),
      .in_side   ({pstep_i_ff, tpitch_i_ff}),
      .out_valid (pd_valid),
      .out_quot  (pquot),
      .out_side  (pd_side)
   );

   // output register
   logic signed [STEP_W-1:0] ystep_ff, pstep_ff;
   logic [SPD_W-1:0]         hspd_ff, vspd_ff;
   logic signed [ANG_W-1:0]  tyaw_ff;
   logic signed [TP_W-1:0]   tpitch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= yd_valid && pd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         {ystep_ff, tyaw_ff}   <= yd_side;
         {pstep_ff, tpitch_ff} <= pd_side;
         hspd_ff <= (yquot > DIV_W'(SPEED_MAX)) ? SPD_W'(SPEED_MAX) : SPD_W'(yquot);
         vspd_ff <= (pquot > DIV_W'(SPEED_MAX)) ? SPD_W'(SPEED_MAX) : SPD_W'(pquot);
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.yaw_step         = ystep_ff;
   assign rsp_ch.pitch_step       = pstep_ff;
   assign rsp_ch.horizontal_speed = hspd_ff;
   assign rsp_ch.vertical_speed   = vspd_ff;
   assign rsp_ch.target_yaw       = tyaw_ff;
   assign rsp_ch.target_pitch     = tpitch_ff;

   // checks
   a_yaw_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (tyaw_ff <= 16'sd23040 && tyaw_ff >= -16'sd23040))
      else $error("target yaw out of range");

   a_pitch_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (tpitch_ff <= 15'sd11520 && tpitch_ff >= -15'sd11520))
      else $error("target pitch out of range");

   a_yaw_still : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ystep_ff == '0) |-> hspd_ff == '0)
      else $error("yaw speed without yaw step");

   a_pitch_still : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && pstep_ff == '0) |-> vspd_ff == '0)
      else $error("pitch speed without pitch step");

endmodule
